### hw/rtl/gfp_pkg.sv
// Shared types and constants for the gamepad frame poller.
`timescale 1ns / 1ps

package gfp_pkg;

   localparam int unsigned FRAME_BYTES = 9;
   localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COMMAND     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_COMMAND      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD_TICKS = 2'd2;

   localparam logic [7:0] START_COMMAND_RESET     = 8'h01;
   localparam logic [7:0] POLL_COMMAND_RESET      = 8'h42;
   localparam logic [7:0] HALF_PERIOD_TICKS_RESET = 8'd10;

   localparam logic [2:0] LAST_BIT  = 3'd7;
   localparam logic [7:0] TICK_MAX  = 8'hFF;

   typedef struct packed {
      logic poll_request;
      logic data_line;
   } req_type;

   typedef struct packed {
      logic       attention_level;
      logic       command_level;
      logic       clock_level;
      logic       byte_valid;
      logic [3:0] byte_index;
      logic [7:0] byte_value;
      logic       frame_done;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_command;
      logic [7:0] poll_command;
      logic [7:0] half_period_ticks;
   } cfg_type;

endpackage

### hw/rtl/gfp_csr.sv
// Configuration registers of the gamepad frame poller.
`timescale 1ns / 1ps

module gfp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_data,
   output gfp_pkg::cfg_type                  cfg
);
   import gfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_COMMAND:     cfg_in.start_command     = csr_data;
            CSR_POLL_COMMAND:      cfg_in.poll_command      = csr_data;
            CSR_HALF_PERIOD_TICKS: cfg_in.half_period_ticks = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_command     <= START_COMMAND_RESET;
         cfg_ff.poll_command      <= POLL_COMMAND_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/gfp_engine.sv
// Serial link state and the per-tick update of the gamepad frame poller.
`timescale 1ns / 1ps

module gfp_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  gfp_pkg::req_type item,
   input  gfp_pkg::cfg_type cfg,
   output gfp_pkg::rsp_type result
);
   import gfp_pkg::*;

   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       bit_ff, bit_in;
   logic             phase_ff, phase_in;
   logic [7:0]       tick_ff, tick_in;
   logic [7:0]       tx_ff, tx_in;
   logic [7:0]       rx_ff, rx_in;
   logic [7:0]       first_ff, first_in;

   logic [7:0]       half;
   logic [7:0]       tick_inc;
   logic [POS_W:0]   pos_inc;

   assign half     = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 8'd1;
   assign pos_inc  = {1'b0, pos_ff} + (POS_W+1)'(1);

   always_comb begin
      active_in         = active_ff;
      pos_in            = pos_ff;
      bit_in            = bit_ff;
      phase_in          = phase_ff;
      tick_in           = tick_ff;
      tx_in             = tx_ff;
      rx_in             = rx_ff;
      first_in          = first_ff;
      result.byte_valid = 1'b0;
      result.byte_index = 4'd0;
      result.byte_value = 8'd0;
      result.frame_done = 1'b0;
      if (!active_ff) begin
         if (item.poll_request) begin
            active_in = 1'b1;
            pos_in    = '0;
            bit_in    = 3'd0;
            phase_in  = 1'b0;
            tick_in   = 8'd0;
            tx_in     = cfg.start_command;
            rx_in     = 8'd0;
         end
      end else if (tick_inc >= half) begin
         tick_in = 8'd0;
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            rx_in    = {item.data_line, rx_ff[7:1]};
            tx_in    = {1'b0, tx_ff[7:1]};
            if (bit_ff == LAST_BIT) begin
               bit_in            = 3'd0;
               result.byte_valid = 1'b1;
               result.byte_index = 4'(pos_ff);
               result.byte_value = rx_in;
               if (pos_ff == '0) begin
                  first_in = rx_in;
               end
               pos_in = pos_inc[POS_W-1:0];
               if (pos_inc >= (POS_W+1)'(FRAME_BYTES)) begin
                  result.frame_done = 1'b1;
                  active_in         = 1'b0;
                  pos_in            = '0;
               end else if (pos_inc == (POS_W+1)'(1)) begin
                  tx_in = cfg.poll_command;
               end else begin
                  tx_in = first_ff;
               end
            end else begin
               bit_in = bit_ff + 3'd1;
            end
         end
      end else begin
         tick_in = tick_inc;
      end
      result.attention_level = !active_in;
      result.command_level   = active_in ? tx_in[0] : 1'b1;
      result.clock_level     = active_in ? !phase_in : 1'b1;
      result.busy_res        = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         bit_ff    <= 3'd0;
         phase_ff  <= 1'b0;
         tick_ff   <= 8'd0;
         tx_ff     <= 8'd0;
         rx_ff     <= 8'd0;
         first_ff  <= 8'd0;
      end else if (step) begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         bit_ff    <= bit_in;
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         tx_ff     <= tx_in;
         rx_ff     <= rx_in;
         first_ff  <= first_in;
      end
   end

endmodule

### hw/rtl/gamepad_frame_poller.sv
// Top level of the gamepad frame poller: input and result registers around the link engine.
`timescale 1ns / 1ps

// Each transfer on the request channel is one time tick of the serial link and yields
// exactly one transfer on the response channel carrying the line levels after that tick.
// The block takes one tick per clock cycle while the response side does not stall; a tick
// passes from the input register through the engine's update logic into the result register.
// Configuration writes are always ready and are meant to be made while no frame is in
// progress.
module gamepad_frame_poller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gfp_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gfp_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);
   import gfp_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   cfg_type cfg;
   logic    advance;
   logic    step;
   logic    accept;

   gfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gfp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? step : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         out_item_ff <= result;
      end
   end

   // A completed frame always reports its last byte in the same transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.frame_done |-> rsp_item.byte_valid && !rsp_item.busy_res)
      else $error("frame_done without a completed byte");

   // Attention is low exactly while a frame is in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.busy_res != rsp_item.attention_level)
      else $error("attention and busy disagree");

   // An idle link holds command and clock high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.busy_res |-> rsp_item.command_level && rsp_item.clock_level)
      else $error("idle link lines not high");

   // A held tick is not lost while the response side stalls.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |=> in_valid_ff && $stable(in_item_ff))
      else $error("held tick dropped during stall");

endmodule
